// File: design/lsd_pkg.sv
// Shared types and constants for the 3D line stepper.
// No dependencies; every other design file imports this package.
package lsd_pkg;

    localparam int COORD_W = 32;             // coordinate width
    localparam int SPAN_W  = COORD_W + 1;    // absolute span per axis
    localparam int ERR_W   = COORD_W + 2;    // offset error terms and thresholds

    localparam int IN_FIELDS_W  = 6 * COORD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * COORD_W + 6;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        action_t      action;
        coord_t [2:0] stop;
        coord_t [2:0] start;
    } in_item_t;

    // Classified command handed from the front end to the stepping engine.
    typedef struct packed {
        action_t                  action;
        logic [2:0][COORD_W-1:0]  pos;
        logic [2:0]               sign;
        axis_t                    major;
        logic [SPAN_W-1:0]        span_major;
        logic [1:0][ERR_W-1:0]    thr;
        logic [1:0][ERR_W-1:0]    inc;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [2:0][1:0]         step;
        logic [2:0][COORD_W-1:0] pos;
        logic                    last;
        logic                    done;
    } res_t;

endpackage

// File: design/lsd_front.sv
// Front end of the line stepper: two-stage classifier that turns load items into
// spans, directions, driving axis and error thresholds. Depends on lsd_pkg.
module lsd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lsd_pkg::in_item_t s_item,
    input  lsd_pkg::q_stat_t  q_stat,
    output logic           push,
    output lsd_pkg::cmd_t  push_cmd
);
    import lsd_pkg::*;

    // stage A: spans and directions
    logic                    a_valid_reg, a_valid_next;
    action_t                 a_action_reg;
    logic [2:0][COORD_W-1:0] a_pos_reg;
    logic [2:0]              a_sign_reg, a_sign_next;
    logic [2:0][SPAN_W-1:0]  a_span_reg, a_span_next;

    // stage B: full command
    logic b_valid_reg, b_valid_next;
    cmd_t b_cmd_reg, b_cmd_next;

    logic a_ready, b_ready;

    assign b_ready = !b_valid_reg || !q_stat.full;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;
    assign push     = b_valid_reg && !q_stat.full;
    assign push_cmd = b_cmd_reg;

    always_comb begin
        logic signed [SPAN_W-1:0] ext_s, ext_e, fwd, rev;
        logic gt;
        for (int i = 0; i < 3; i++) begin
            ext_s = {s_item.start[i][COORD_W-1], s_item.start[i]};
            ext_e = {s_item.stop[i][COORD_W-1], s_item.stop[i]};
            fwd   = ext_e - ext_s;
            rev   = ext_s - ext_e;
            gt    = $signed(s_item.stop[i]) > $signed(s_item.start[i]);
            a_sign_next[i] = !gt;
            a_span_next[i] = gt ? fwd : rev;
        end
    end

    // Pairwise span differences: the sign bit gives the compare, and the
    // difference against the driving axis gives the minor threshold.
    function automatic logic [ERR_W-1:0] span_diff(input logic [SPAN_W-1:0] a,
                                                    input logic [SPAN_W-1:0] b);
        return ERR_W'(a) - ERR_W'(b);
    endfunction

    always_comb begin
        logic [ERR_W-1:0] d01, d02, d12, d10, d20, d21;
        logic ge01, ge02, ge12;
        d01 = span_diff(a_span_reg[0], a_span_reg[1]);
        d02 = span_diff(a_span_reg[0], a_span_reg[2]);
        d12 = span_diff(a_span_reg[1], a_span_reg[2]);
        d10 = span_diff(a_span_reg[1], a_span_reg[0]);
        d20 = span_diff(a_span_reg[2], a_span_reg[0]);
        d21 = span_diff(a_span_reg[2], a_span_reg[1]);
        ge01 = !d01[ERR_W-1];
        ge02 = !d02[ERR_W-1];
        ge12 = !d12[ERR_W-1];

        b_cmd_next.action = a_action_reg;
        b_cmd_next.pos    = a_pos_reg;
        b_cmd_next.sign   = a_sign_reg;
        if (ge01 && ge02) begin
            b_cmd_next.major      = AXIS_X;
            b_cmd_next.span_major = a_span_reg[0];
            b_cmd_next.thr[0]     = {d01[ERR_W-2:0], 1'b0};
            b_cmd_next.thr[1]     = {d02[ERR_W-2:0], 1'b0};
            b_cmd_next.inc[0]     = {a_span_reg[1], 1'b0};
            b_cmd_next.inc[1]     = {a_span_reg[2], 1'b0};
        end else if (ge12) begin
            b_cmd_next.major      = AXIS_Y;
            b_cmd_next.span_major = a_span_reg[1];
            b_cmd_next.thr[0]     = {d10[ERR_W-2:0], 1'b0};
            b_cmd_next.thr[1]     = {d12[ERR_W-2:0], 1'b0};
            b_cmd_next.inc[0]     = {a_span_reg[0], 1'b0};
            b_cmd_next.inc[1]     = {a_span_reg[2], 1'b0};
        end else begin
            b_cmd_next.major      = AXIS_Z;
            b_cmd_next.span_major = a_span_reg[2];
            b_cmd_next.thr[0]     = {d20[ERR_W-2:0], 1'b0};
            b_cmd_next.thr[1]     = {d21[ERR_W-2:0], 1'b0};
            b_cmd_next.inc[0]     = {a_span_reg[0], 1'b0};
            b_cmd_next.inc[1]     = {a_span_reg[1], 1'b0};
        end
    end

    assign a_valid_next = a_ready ? s_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && a_ready) begin
            a_action_reg <= s_item.action;
            a_pos_reg    <= s_item.start;
            a_sign_reg   <= a_sign_next;
            a_span_reg   <= a_span_next;
        end
        if (a_valid_reg && b_ready) begin
            b_cmd_reg <= b_cmd_next;
        end
    end

endmodule

// File: design/lsd_queue.sv
// Short command queue between the front end and the stepping engine.
// Depends on lsd_pkg for the command type and depth.
module lsd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lsd_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output lsd_pkg::cmd_t    head_cmd,
    output lsd_pkg::q_stat_t stat
);
    import lsd_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    assign count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/lsd_back.sv
// Stepping engine: holds the segment state and runs one command per cycle
// into the result register unless stalled or idle. Depends on lsd_pkg.
module lsd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  lsd_pkg::q_stat_t q_stat,
    input  lsd_pkg::cmd_t    head_cmd,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output lsd_pkg::res_t    m_res
);
    import lsd_pkg::*;

    logic [2:0][COORD_W-1:0] pos_reg, pos_next;
    logic [2:0]              sign_reg, sign_next;
    axis_t                   major_reg, major_next;
    logic [1:0][ERR_W-1:0]   thr_reg, thr_next;
    logic [1:0][ERR_W-1:0]   inc_reg, inc_next;
    logic [1:0][ERR_W-1:0]   err_reg, err_next;
    logic [SPAN_W-1:0]       remaining_reg, remaining_next;

    logic m_valid_reg, m_valid_next;
    res_t res_reg, res_next;

    // advance datapath
    logic [1:0]              take;
    logic [1:0][ERR_W-1:0]   err_adv;
    logic [2:0]              moves;
    logic [2:0][1:0]         step_adv;
    logic [2:0][COORD_W-1:0] pos_adv;

    assign pop          = !q_stat.empty && (!m_valid_reg || m_ready);
    assign m_valid_next = pop ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_valid      = m_valid_reg;
    assign m_res        = res_reg;

    // Minor axes in ascending order for the given driving axis.
    function automatic logic [1:0] minor_axis(input axis_t major, input int k);
        logic [1:0] lo;
        logic [1:0] hi;
        case (major)
            AXIS_X:  begin lo = 2'd1; hi = 2'd2; end
            AXIS_Y:  begin lo = 2'd0; hi = 2'd2; end
            default: begin lo = 2'd0; hi = 2'd1; end
        endcase
        return (k == 0) ? lo : hi;
    endfunction

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            take[k]    = err_reg[k] >= thr_reg[k];
            err_adv[k] = take[k] ? err_reg[k] - thr_reg[k] : err_reg[k] + inc_reg[k];
        end
        for (int i = 0; i < 3; i++) begin
            moves[i] = (2'(i) == major_reg)
                     || ((2'(i) == minor_axis(major_reg, 0)) && take[0])
                     || ((2'(i) == minor_axis(major_reg, 1)) && take[1]);
            if (!moves[i]) begin
                step_adv[i] = STEP_NONE;
                pos_adv[i]  = pos_reg[i];
            end else if (sign_reg[i]) begin
                step_adv[i] = STEP_NEG;
                pos_adv[i]  = pos_reg[i] - 1'b1;
            end else begin
                step_adv[i] = STEP_POS;
                pos_adv[i]  = pos_reg[i] + 1'b1;
            end
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        sign_next      = sign_reg;
        major_next     = major_reg;
        thr_next       = thr_reg;
        inc_next       = inc_reg;
        err_next       = err_reg;
        remaining_next = remaining_reg;
        res_next.pos   = pos_reg;
        res_next.step  = {3{STEP_NONE}};
        res_next.last  = 1'b0;
        res_next.done  = 1'b0;
        case (head_cmd.action)
            ACT_LOAD: begin
                pos_next       = head_cmd.pos;
                sign_next      = head_cmd.sign;
                major_next     = head_cmd.major;
                thr_next       = head_cmd.thr;
                inc_next       = head_cmd.inc;
                err_next[0]    = ERR_W'(head_cmd.span_major);
                err_next[1]    = ERR_W'(head_cmd.span_major);
                remaining_next = head_cmd.span_major;
                res_next.pos   = head_cmd.pos;
                res_next.last  = (head_cmd.span_major == '0);
            end
            ACT_STEP: begin
                if (remaining_reg == '0) begin
                    res_next.done = 1'b1;
                end else begin
                    pos_next       = pos_adv;
                    err_next       = err_adv;
                    remaining_next = remaining_reg - 1'b1;
                    res_next.pos   = pos_adv;
                    res_next.step  = step_adv;
                    res_next.last  = (remaining_reg == SPAN_W'(1));
                end
            end
            default: begin
                res_next.done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            pos_reg       <= '0;
            sign_reg      <= '0;
            major_reg     <= AXIS_X;
            thr_reg       <= '0;
            inc_reg       <= '0;
            err_reg       <= '0;
            remaining_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                pos_reg       <= pos_next;
                sign_reg      <= sign_next;
                major_reg     <= major_next;
                thr_reg       <= thr_next;
                inc_reg       <= inc_next;
                err_reg       <= err_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

// File: design/line_stepper_3d_unit.sv
// Top level of the 3D Bresenham line stepper: front end, command queue and
// stepping engine. Depends on lsd_pkg, lsd_front, lsd_queue, lsd_back.
//
//  channel | ports     | tdata (low bit up)                       | tuser    | tlast
//  --------+-----------+------------------------------------------+----------+------
//  in      | s_axis_*  | start_x, start_y, start_z, end_x, end_y, | action   | -
//          |           | end_z (32 bits each)                     |          |
//  out     | m_axis_*  | pos_x, pos_y, pos_z (32 each), step_x,   | done_res | last
//          |           | step_y, step_z (2 each), 2 zero bits     |          |
//
// Flow: one item per cycle while m_axis_tready stays high; an item passes front
//   stage A (loaded on the accepting edge), stage B, a queue slot and then the
//   result register. The per-step loop is one compare and one add or subtract
//   per minor error term, held in the stepping engine, so step items keep that
//   rate too.
// Reset: aresetn low clears the queue, the valids and the segment state (origin,
//   nothing left to walk), so a step item right after reset returns a done item.
// Stalls: the result register keeps its item while m_axis_tready is low; the
//   four-entry queue absorbs the front end's in-flight items, and s_axis_tready
//   drops only once the queue is full and the front stages are occupied.
module line_stepper_3d_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [lsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, pos_z, step_x, step_y, step_z
    output logic [lsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // done_res
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);
    import lsd_pkg::*;

    in_item_t s_item;
    q_stat_t  q_stat;
    cmd_t     push_cmd, head_cmd;
    logic     push, pop;
    res_t     m_res;

    // unpack the input item
    always_comb begin
        s_item.action = action_t'(s_axis_tuser);
        for (int i = 0; i < 3; i++) begin
            s_item.start[i] = s_axis_tdata[i * COORD_W +: COORD_W];
            s_item.stop[i]  = s_axis_tdata[(3 + i) * COORD_W +: COORD_W];
        end
    end

    lsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_item   (s_item),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    lsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_res    (m_res)
    );

    // pack the result item: positions low, step codes above, zero fill on top
    assign m_axis_tdata = OUT_TDATA_W'({m_res.step, m_res.pos});
    assign m_axis_tlast = m_res.last;
    assign m_axis_tuser = m_res.done;

    // a done item never moves and never closes a segment
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            !m_axis_tlast && (m_res.step == {3{STEP_NONE}}))
        else $error("done item with motion or last flag");

    // no axis ever jumps by two
    a_step_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_res.step[0] != 2'b10) && (m_res.step[1] != 2'b10)
                       && (m_res.step[2] != 2'b10))
        else $error("illegal step code");

    // queue status flags are exclusive
    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // results drop out of reset empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// File: verif/line_stepper_3d_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_stepper_3d_unit: directed table, then random
// line segments walked point by point, checked against a cycle-free line walker.
// Depends on lsd_pkg and the line_stepper_3d_unit design sources.
module line_stepper_3d_unit_test;
    import lsd_pkg::*;

    localparam int     CLK_HALF    = 5;
    localparam int     RAND_ITEMS  = 1250;
    localparam int     CALM_ITEMS  = 150;      // tail of the run with no idling
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     DRAIN_WAIT  = 8;        // extra wait for a late stray result
    localparam coord_t CMIN        = 32'sh8000_0000;
    localparam coord_t CMAX        = 32'sh7fff_ffff;

    typedef coord_t [2:0] triple_t;

    // One emitted point; index 0 of each packed array is the X axis.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] pos;
        logic [2:0][1:0]         step;
        logic                    last;
        logic                    done;
    } point_t;

    // Directed row: item, then (when typed) the point it must produce. Typed
    // rows are loads and done items, so their steps are always zero.
    typedef struct packed {
        action_t act;
        coord_t  sx, sy, sz;
        coord_t  ex, ey, ez;
        logic    typed;
        coord_t  wx, wy, wz;
        logic    wlast;
        logic    wdone;
    } drill_row_t;

    localparam int DRILL_LEN = 24;
    localparam drill_row_t DRILL [DRILL_LEN] = '{
        // step right after reset: done item at the origin
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0, 1'b1},
        // zero-length line, then a done item holding it
        '{ACT_LOAD, 5, -7, 3, 5, -7, 3, 1'b1, 5, -7, 3, 1'b1, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b1, 5, -7, 3, 1'b0, 1'b1},
        // full-range diagonal, three-way tie goes to X
        '{ACT_LOAD, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1, CMIN, CMIN, CMIN, 1'b0, 1'b0},
        '{ACT_STEP, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        // X falling, Z rising over full range, Y zero span
        '{ACT_LOAD, CMAX, 0, CMIN, CMIN, 0, CMAX, 1'b1, CMAX, 0, CMIN, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        // Y/Z tie goes to Y; walk to the end and one past
        '{ACT_LOAD, 0, 0, 0, 3, 5, 5, 1'b1, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b1, 3, 5, 5, 1'b0, 1'b1},
        // negative directions; Z has zero span so never steps
        '{ACT_LOAD, 10, 10, 10, 8, 9, 10, 1'b1, 10, 10, 10, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b1, 8, 9, 10, 1'b0, 1'b1},
        // Z major with mixed minor directions
        '{ACT_LOAD, -1, 2, 0, 0, 0, 3, 1'b1, -1, 2, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 3, 1'b0, 1'b1}
    };

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    line_stepper_3d_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #CLK_HALF aclk = ~aclk;

    // ---------------------------------------------------------------
    // Line walker: own copy of the segment state
    // ---------------------------------------------------------------
    coord_t            walk_pos  [3];
    logic              walk_neg  [3];
    logic [SPAN_W-1:0] walk_span [3];
    logic [ERR_W-1:0]  walk_err  [2];
    axis_t             walk_major;
    logic [SPAN_W-1:0] walk_left;

    point_t pending_points [$];      // points owed by the block, oldest first
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    int     src_pct        = 0;      // chance of a sender gap before an item
    int     sink_pct       = 0;      // chance of a receiver stall per cycle
    bit     calm           = 1'b0;   // no idling on either side

    task automatic walker_reset();
        for (int i = 0; i < 3; i++) begin
            walk_pos[i]  = '0;
            walk_neg[i]  = 1'b0;
            walk_span[i] = '0;
        end
        walk_err[0] = '0;
        walk_err[1] = '0;
        walk_major  = AXIS_X;
        walk_left   = '0;
    endtask

    // Advance the walker by one item and return the point it emits.
    function automatic point_t walk_item(input action_t act, input triple_t from,
                                         input triple_t to);
        point_t            pt;
        int                minor [2];
        logic [SPAN_W-1:0] dm;
        logic [ERR_W-1:0]  thr;
        pt = '0;
        if (act == ACT_LOAD) begin
            for (int i = 0; i < 3; i++) begin
                walk_pos[i] = from[i];
                walk_neg[i] = !(to[i] > from[i]);
                // 33-bit difference of sign-extended ends never overflows
                if (to[i] > from[i])
                    walk_span[i] = {to[i][COORD_W-1], to[i]} - {from[i][COORD_W-1], from[i]};
                else
                    walk_span[i] = {from[i][COORD_W-1], from[i]} - {to[i][COORD_W-1], to[i]};
            end
            if (walk_span[0] >= walk_span[1] && walk_span[0] >= walk_span[2])
                walk_major = AXIS_X;
            else if (walk_span[1] >= walk_span[2])
                walk_major = AXIS_Y;
            else
                walk_major = AXIS_Z;
            walk_err[0] = ERR_W'(walk_span[walk_major]);
            walk_err[1] = ERR_W'(walk_span[walk_major]);
            walk_left   = walk_span[walk_major];
            pt.last     = (walk_left == 0);
        end else if (walk_left == 0) begin
            pt.done = 1'b1;
        end else begin
            case (walk_major)
                AXIS_X:  begin minor[0] = 1; minor[1] = 2; end
                AXIS_Y:  begin minor[0] = 0; minor[1] = 2; end
                default: begin minor[0] = 0; minor[1] = 1; end
            endcase
            dm = walk_span[walk_major];
            pt.step[walk_major] = walk_neg[walk_major] ? STEP_NEG : STEP_POS;
            // offset error terms stay in [0, 2*dm], so no sign is needed
            for (int k = 0; k < 2; k++) begin
                thr = (ERR_W'(dm) - ERR_W'(walk_span[minor[k]])) << 1;
                if (walk_err[k] >= thr) begin
                    walk_err[k]         = walk_err[k] - thr;
                    pt.step[minor[k]]   = walk_neg[minor[k]] ? STEP_NEG : STEP_POS;
                end else begin
                    walk_err[k] = walk_err[k] + (ERR_W'(walk_span[minor[k]]) << 1);
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (pt.step[i] == STEP_POS)
                    walk_pos[i] = walk_pos[i] + 1;
                else if (pt.step[i] == STEP_NEG)
                    walk_pos[i] = walk_pos[i] - 1;
            end
            walk_left = walk_left - 1'b1;
            pt.last   = (walk_left == 0);
        end
        for (int i = 0; i < 3; i++)
            pt.pos[i] = walk_pos[i];
        return pt;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Drive one item, wait for the handshake and book the point it owes.
    // A gap lowers tvalid only when it is followed by at least one idle edge.
    task automatic send_item(input action_t act, input triple_t from, input triple_t to,
                             input bit typed, input point_t want);
        point_t pt;
        if (!calm && $urandom_range(0, 99) < src_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {to[2], to[1], to[0], from[2], from[1], from[0]};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pt = walk_item(act, from, to);
        if (typed)
            pt = want;
        pending_points = {pending_points, pt};
    endtask

    function automatic triple_t any_coords();
        triple_t c;
        for (int i = 0; i < 3; i++)
            c[i] = $urandom;
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Result checker: sampled at the edge, before the block updates
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : check_points
        point_t want;
        point_t got;
        string  axis_tag;
        axis_tag = "xyz";
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            for (int i = 0; i < 3; i++) begin
                got.pos[i]  = m_axis_tdata[i*COORD_W +: COORD_W];
                got.step[i] = m_axis_tdata[3*COORD_W + 2*i +: 2];
            end
            got.last = m_axis_tlast;
            got.done = m_axis_tuser;
            if (pending_points.size() == 0) begin
                flag_mismatch("result with no item waiting on it");
            end else begin
                want = pending_points.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got.pos[i] !== want.pos[i])
                        flag_mismatch($sformatf("pos_%c got %0d want %0d", axis_tag[i],
                            $signed(got.pos[i]), $signed(want.pos[i])));
                    if (got.step[i] !== want.step[i])
                        flag_mismatch($sformatf("step_%c got %b want %b", axis_tag[i],
                            got.step[i], want.step[i]));
                end
                if (got.last !== want.last)
                    flag_mismatch($sformatf("last got %b want %b", got.last, want.last));
                if (got.done !== want.done)
                    flag_mismatch($sformatf("done_res got %b want %b", got.done, want.done));
            end
        end
    end

    // Receiver: ready high except for random stall bursts.
    initial begin
        repeat (11) @(posedge aclk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 99) < sink_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        triple_t    from;
        triple_t    to;
        point_t     want;
        drill_row_t row;
        int         rand_sent;
        int         pick;
        int         reach;
        int         walk_n;

        walker_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        src_pct  = 25;
        sink_pct = 25;
        for (int r = 0; r < DRILL_LEN; r++) begin
            row       = DRILL[r];
            from      = {row.sz, row.sy, row.sx};
            to        = {row.ez, row.ey, row.ex};
            want      = '0;
            want.pos  = {row.wz, row.wy, row.wx};
            want.last = row.wlast;
            want.done = row.wdone;
            send_item(row.act, from, to, row.typed, want);
        end

        // random segments: mostly well-formed walks, some wild loads and noise
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            calm     = (rand_sent >= RAND_ITEMS - CALM_ITEMS);
            src_pct  = $urandom_range(0, 4) * 12;
            sink_pct = $urandom_range(0, 4) * 12;
            pick     = $urandom_range(0, 99);
            if (pick < 75) begin
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 2))
                        0:       from[i] = int'($urandom_range(0, 100)) - 50;
                        1:       from[i] = $urandom;
                        default: from[i] = $urandom_range(0, 1) ?
                                           CMAX - $urandom_range(0, 15) :
                                           CMIN + $urandom_range(0, 15);
                    endcase
                    reach = ($urandom_range(0, 7) == 0) ? 200 : 12;
                    // near the extremes this may wrap into a huge span
                    to[i] = from[i] + (int'($urandom_range(0, 2 * reach)) - reach);
                end
                if ($urandom_range(0, 11) == 0)
                    to = from;
                send_item(ACT_LOAD, from, to, 1'b0, '0);
                // walk to the end and a little past, now and then stopping short; long lines get a few points
                walk_n = (walk_left > 400) ? $urandom_range(1, 8)
                                           : int'(walk_left) + $urandom_range(0, 3);
                if ($urandom_range(0, 9) == 0)
                    walk_n = $urandom_range(0, walk_n);
                repeat (walk_n)
                    send_item(ACT_STEP, any_coords(), any_coords(), 1'b0, '0);
                rand_sent += 1 + walk_n;
            end else if (pick < 90) begin
                send_item(ACT_LOAD, any_coords(), any_coords(), 1'b0, '0);
                walk_n = $urandom_range(0, 4);
                repeat (walk_n)
                    send_item(ACT_STEP, any_coords(), any_coords(), 1'b0, '0);
                rand_sent += 1 + walk_n;
            end else begin
                send_item(action_t'($urandom_range(0, 1)), any_coords(), any_coords(),
                          1'b0, '0);
                rand_sent += 1;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give a late stray result time to show up
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
design/lsd_pkg.sv
design/lsd_front.sv
design/lsd_queue.sv
design/lsd_back.sv
design/line_stepper_3d_unit.sv
verif/line_stepper_3d_unit_test.sv
